[design/assert_macros.svh]
// Shared assertion macros for the tone synthesizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/stts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stts_pkg;

  // Default module parameters
  localparam int unsigned TONE_COUNT_DFLT  = 7;
  localparam int unsigned SINE_DEPTH_DFLT  = 1024;
  localparam int unsigned SAMPLE_BITS_DFLT = 16;

  // Fixed field widths
  localparam int unsigned COLUMN_W   = 7;
  localparam int unsigned SIDX_W     = 17;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned TONE_LEN_W = 16;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [PHASE_W-1:0]    RST_BASE_STEP    = 32'd89478485;
  localparam logic [PHASE_W-1:0]    RST_SPACING_STEP = 32'd17895697;
  localparam logic [PHASE_W-1:0]    RST_ENV_STEP     = 32'd894785;
  localparam logic [TONE_LEN_W-1:0] RST_TONE_LEN     = 16'd2400;

  // Final scale: divide by 7 through a reciprocal multiply
  localparam int unsigned DIV_NUM     = 7;
  localparam int unsigned DIV_SHIFT   = 23;
  localparam int unsigned DIV_RECIP   = ((1 << DIV_SHIFT) + DIV_NUM - 1) / DIV_NUM;
  localparam int unsigned DIV_RECIP_W = 21;

  // Sine generator constants (Q30)
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_STEP    = 3'd0,
    CFG_SPACING_STEP = 3'd1,
    CFG_ENV_STEP     = 3'd2,
    CFG_TONE_LEN     = 3'd3,
    CFG_GAP_LEN      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [COLUMN_W-1:0] column_bits;
    logic [SIDX_W-1:0]   sample_index;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_value;
    logic                    in_tone;
  } out_word_t;

  // sin of r/2^30 quarter turns, degree-13 Taylor series, scaled to full scale
  function automatic longint quarter_sine(longint unsigned r, int unsigned sbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          peak;
    int              n;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    peak = (longint'(1) << (sbits - 1)) - 1;
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return (sum * peak + (longint'(1) << 29)) >> 30;
  endfunction

endpackage

`default_nettype wire

[design/stts_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none

// Full-turn sine lookup folded onto a quarter-wave constant table.
// Depth must be a power of two; the module itself does not enforce it.
module stts_sine_rom import stts_pkg::*; #(
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DFLT,
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DFLT
) (
  input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_i,
  output logic signed [SAMPLE_BITS-1:0]            data_o
);

  localparam int unsigned AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QD    = SINE_TABLE_DEPTH / 4;
  localparam int unsigned QI_W  = AW - 1;
  localparam int unsigned MAG_W = SAMPLE_BITS - 1;

  // Quarter table, entries 0..QD inclusive (QD holds the peak)
  logic [MAG_W-1:0] qtab [QD+1];

  for (genvar i = 0; i <= QD; i++) begin : g_qtab
    assign qtab[i] = MAG_W'(quarter_sine(64'(i) << (PHASE_W - AW), SAMPLE_BITS));
  end

  logic [1:0]              quad;
  logic [AW-3:0]           off;
  logic [QI_W-1:0]         qidx;
  logic [MAG_W-1:0]        mag;
  logic signed [SAMPLE_BITS-1:0] smag;

  // Odd quadrants run the table backwards, upper half is negated
  assign quad   = addr_i[AW-1:AW-2];
  assign off    = addr_i[AW-3:0];
  assign qidx   = quad[0] ? (QI_W'(QD) - QI_W'(off)) : QI_W'(off);
  assign mag    = qtab[qidx];
  assign smag   = signed'({1'b0, mag});
  assign data_o = quad[1] ? -smag : smag;

endmodule

`default_nettype wire

[design/spectrogram_text_tone_synth_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Additive sine tone synthesizer with half-sine envelope.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per audio sample,
//   a 7-bit font column and the sample index within that column's slot.
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per input word,
//   a saturated Q1.15 sample and an in_tone flag; gap indices give zero.
// Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): write-only, one register per
//   write, to be used only while the pipe is empty.
// Throughput: one word per cycle while out_stall_i is low. Pipeline: eight register
//   stages, from the input capture register to the output register.
// Stage cut: index compare, phase multiply per lane, sine lookup, tone sum,
//   envelope multiply, rounding, reciprocal multiply by 1/7, saturation.
// Reset clears the pipe and loads the default phase steps and tone length.
// When the receiver stalls, the output word holds and bubbles upstream are
//   squeezed out; input stall rises only once every stage is full.
module spectrogram_text_tone_synth_top import stts_pkg::*; #(
  parameter int unsigned TONE_COUNT       = TONE_COUNT_DFLT,
  parameter int unsigned SINE_TABLE_DEPTH = SINE_DEPTH_DFLT,
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DFLT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_word_t              in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_word_t                  out_word_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

`include "assert_macros.svh"

  localparam int unsigned AW       = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned NL       = TONE_COUNT + 1;
  localparam int unsigned ENV_LANE = TONE_COUNT;
  localparam int unsigned NSTG     = 8;
  localparam int unsigned PH_W     = SIDX_W + PHASE_W;
  localparam int unsigned ACC_W    = SAMPLE_BITS + 3;
  localparam int unsigned PROD_W   = 2 * SAMPLE_BITS + 3;
  localparam int unsigned NORM_SH  = 2 * SAMPLE_BITS - 2;
  localparam int unsigned NUM_W    = PROD_W + 16;
  localparam int unsigned T_W      = 20;
  localparam int unsigned MQ_W     = T_W + DIV_RECIP_W;
  localparam int unsigned Q_W      = MQ_W - DIV_SHIFT;

  localparam logic [NUM_W-1:0] RND_TERM = NUM_W'(DIV_NUM) << (NORM_SH - 1);
  localparam logic [Q_W-1:0]   Q_POS_MAX = Q_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [Q_W-1:0]   Q_NEG_MAX = Q_W'(1 << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration registers (gap length only sizes the slot upstream)
  logic [PHASE_W-1:0]    base_step_q, spacing_step_q, env_step_q;
  logic [TONE_LEN_W-1:0] tone_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_step_q    <= RST_BASE_STEP;
      spacing_step_q <= RST_SPACING_STEP;
      env_step_q     <= RST_ENV_STEP;
      tone_len_q     <= RST_TONE_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BASE_STEP:    base_step_q    <= cfg_wdata_i[PHASE_W-1:0];
        CFG_SPACING_STEP: spacing_step_q <= cfg_wdata_i[PHASE_W-1:0];
        CFG_ENV_STEP:     env_step_q     <= cfg_wdata_i[PHASE_W-1:0];
        CFG_TONE_LEN:     tone_len_q     <= cfg_wdata_i[TONE_LEN_W-1:0];
        CFG_GAP_LEN:      ;
        default:          ;
      endcase
    end
  end

  // Per-lane phase step, refreshed every cycle from the config registers
  logic [PHASE_W-1:0] step_q [NL];

  for (genvar k = 0; k < NL; k++) begin : g_step
    if (k == ENV_LANE) begin : g_env
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          step_q[k] <= RST_ENV_STEP;
        end else begin
          step_q[k] <= env_step_q;
        end
      end
    end else begin : g_tone
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          step_q[k] <= PHASE_W'(RST_BASE_STEP + PHASE_W'(k) * RST_SPACING_STEP);
        end else begin
          step_q[k] <= PHASE_W'(base_step_q + PHASE_W'(k) * spacing_step_q);
        end
      end
    end
  end

  // Pipe control: a stage loads when empty or when the next one moves
  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = !out_stall_i;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !vld_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
    end
  end

  assign in_stall_o = !adv[0];

  // Stage 1: capture word, tone/gap decision
  logic [SIDX_W-1:0]   j1_q;
  logic [COLUMN_W-1:0] bits1_q;
  logic                tone1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      j1_q    <= in_word_i.sample_index;
      bits1_q <= in_word_i.column_bits;
      tone1_q <= in_word_i.sample_index < SIDX_W'(tone_len_q);
    end
  end

  // Stage 2: phase = j * step mod 2^32, keep the table address bits
  logic [PH_W-1:0]     ph_full [NL];
  logic [AW-1:0]       idx2_q  [NL];
  logic [TONE_COUNT-1:0] en1, en2_q;
  logic                tone2_q;

  for (genvar k = 0; k < NL; k++) begin : g_phase
    assign ph_full[k] = PH_W'(j1_q) * PH_W'(step_q[k]);
    always_ff @(posedge clk_i) begin
      if (adv[1]) begin
        idx2_q[k] <= ph_full[k][PHASE_W-1 -: AW];
      end
    end
  end

  for (genvar k = 0; k < TONE_COUNT; k++) begin : g_en
    if (k < COLUMN_W) begin : g_bit
      assign en1[k] = bits1_q[k];
    end else begin : g_none
      assign en1[k] = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      en2_q   <= en1;
      tone2_q <= tone1_q;
    end
  end

  // Stage 3: sine lookup per lane, disabled tones read as zero
  logic signed [SAMPLE_BITS-1:0] rom_val [NL];
  logic signed [SAMPLE_BITS-1:0] sin3_q  [NL];
  logic                          tone3_q;

  for (genvar k = 0; k < NL; k++) begin : g_lut
    stts_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_rom (
      .addr_i (idx2_q[k]),
      .data_o (rom_val[k])
    );

    if (k == ENV_LANE) begin : g_env
      always_ff @(posedge clk_i) begin
        if (adv[2]) begin
          sin3_q[k] <= rom_val[k];
        end
      end
    end else begin : g_tone
      always_ff @(posedge clk_i) begin
        if (adv[2]) begin
          sin3_q[k] <= en2_q[k] ? rom_val[k] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      tone3_q <= tone2_q;
    end
  end

  // Stage 4: sum of the enabled tones
  logic signed [ACC_W-1:0]       acc_d, acc4_q;
  logic signed [SAMPLE_BITS-1:0] env4_q;
  logic                          tone4_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < TONE_COUNT; k++) begin
      acc_d = acc_d + ACC_W'(sin3_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      acc4_q  <= acc_d;
      env4_q  <= sin3_q[ENV_LANE];
      tone4_q <= tone3_q;
    end
  end

  // Stage 5: envelope weighting
  logic signed [PROD_W-1:0] prod5_q;
  logic                     tone5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      prod5_q <= PROD_W'(acc4_q) * PROD_W'(env4_q);
      tone5_q <= tone4_q;
    end
  end

  // Stage 6: magnitude, scale to Q15 and round half up before the /7
  logic [PROD_W-1:0] mag5;
  logic [NUM_W-1:0]  num5;
  logic [T_W-1:0]    t6_q;
  logic              neg6_q, tone6_q;

  assign mag5 = prod5_q[PROD_W-1] ? PROD_W'(-prod5_q) : PROD_W'(prod5_q);
  assign num5 = (NUM_W'(mag5) << 15) + RND_TERM;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      t6_q    <= T_W'(num5 >> NORM_SH);
      neg6_q  <= prod5_q[PROD_W-1];
      tone6_q <= tone5_q;
    end
  end

  // Stage 7: floor(t / 7) by reciprocal multiply, exact for t below 2^20
  logic [MQ_W-1:0] qm6;
  logic [Q_W-1:0]  q7_q;
  logic            neg7_q, tone7_q;

  assign qm6 = MQ_W'(t6_q) * MQ_W'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      q7_q    <= Q_W'(qm6 >> DIV_SHIFT);
      neg7_q  <= neg6_q;
      tone7_q <= tone6_q;
    end
  end

  // Stage 8: sign, saturation, gap forcing; output register
  logic signed [OUT_W-1:0] val7;
  out_word_t               out_q;

  always_comb begin
    priority if (!tone7_q) begin
      val7 = '0;
    end else if (neg7_q) begin
      val7 = (q7_q > Q_NEG_MAX) ? OUT_MIN : -signed'(OUT_W'(q7_q));
    end else begin
      val7 = (q7_q > Q_POS_MAX) ? OUT_MAX : signed'(OUT_W'(q7_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      out_q.sample_value <= val7;
      out_q.in_tone      <= tone7_q;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_word_o  = out_q;

  // Checks
  `ASSERT_CLK(a_gap_silent, clk_i, rst_ni,
    out_valid_o && !out_word_o.in_tone |-> out_word_o.sample_value == '0,
    "gap word carries a nonzero sample")
  `ASSERT_CLK(a_stall_full, clk_i, rst_ni,
    in_stall_o |-> (&vld_q),
    "input stalled while the pipe holds a bubble")
  `ASSERT_CLK(a_accept_enters, clk_i, rst_ni,
    in_valid_i && !in_stall_o |=> vld_q[0],
    "accepted word missing from stage one")
  `ASSERT_NEVER(a_stall_no_cause, clk_i, rst_ni,
    in_stall_o && !out_stall_i,
    "input stalled with the output free")

endmodule

`default_nettype wire
